// ===== rtl/circular_queue_with_prepend_core_macros.svh =====
// Assertion macros for the circular queue with prepend.
`ifndef CIRCULAR_QUEUE_WITH_PREPEND_CORE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_PREPEND_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CQP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CQP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CQP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CQP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/cqp_pkg.sv =====
package cqp_pkg;

    // Ring storage geometry.
    localparam int SLOTS     = 16;
    localparam int ITEM_BITS = 32;
    localparam int PTR_W     = $clog2(SLOTS);

    // Capacity and count fields are four bits wide.
    localparam int CAP_W = 4;
    localparam int CNT_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

    // Operation codes carried by a transaction.
    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PREPEND = 2'd2,
        CMD_STATUS  = 2'd3
    } t_cmd;

    // Control sequence of one transaction.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

// ===== rtl/circular_queue_with_prepend_core.sv =====
// Ring queue of up to 15 items kept in a synchronous slot memory of SLOTS entries, with
// head and tail pointers in registers. Each input transaction appends, pops, prepends or
// reads status, and produces exactly one output transaction. One item is in flight at a
// time: a transaction goes from acceptance through the registered read of the slot memory
// to a result presented on the output, and the next input is accepted in the cycle after
// the result is taken, so no new item is taken while a result is pending. Writing the
// capacity register empties the queue; a capacity of zero disables it.
`include "circular_queue_with_prepend_core_macros.svh"

module circular_queue_with_prepend_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration.
    input  logic                          i_cfg_we,
    input  logic [cqp_pkg::CAP_W-1:0]     i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [cqp_pkg::ITEM_BITS-1:0] i_item_data,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [cqp_pkg::ITEM_BITS-1:0] o_popped_data,
    output logic [cqp_pkg::CAP_W-1:0]     o_item_count,
    output logic [cqp_pkg::CAP_W-1:0]     o_free_count,
    output logic                          o_is_full,
    output logic                          o_is_empty
);
    import cqp_pkg::*;

    // Registers.
    t_state                r_state;
    t_state                n_state;
    logic [CAP_W-1:0]      r_cap;
    logic [PTR_W-1:0]      r_head;
    logic [PTR_W-1:0]      r_tail;
    logic                  r_pop_ok;
    logic                  r_ok;
    logic [ITEM_BITS-1:0]  r_popped;
    logic [CAP_W-1:0]      r_item_count;
    logic [CAP_W-1:0]      r_free_count;
    logic                  r_full;
    logic                  r_empty;
    logic [ITEM_BITS-1:0]  r_mem [SLOTS];
    logic [ITEM_BITS-1:0]  r_rd_data;

    // Combinational next values.
    logic [PTR_W-1:0]      n_head;
    logic [PTR_W-1:0]      n_tail;
    logic [CAP_W-1:0]      c_cap_eff;
    logic [PTR_W-1:0]      c_top;
    logic [CNT_W-1:0]      c_ring;
    logic [CNT_W-1:0]      c_count_cur;
    logic [CNT_W-1:0]      c_count_new;
    logic                  c_enabled;
    logic                  c_not_full;
    logic                  c_accept;
    logic                  c_ok;
    logic                  c_we;
    logic [PTR_W-1:0]      c_waddr;
    logic [PTR_W-1:0]      c_head_inc;
    logic [PTR_W-1:0]      c_head_dec;
    logic [PTR_W-1:0]      c_tail_inc;

    // Items held between head and tail in a ring of the given size.
    function automatic logic [CNT_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail,
                                                    input logic [CNT_W-1:0] ring);
        logic [CNT_W-1:0] h;
        logic [CNT_W-1:0] t;
        h = CNT_W'(head);
        t = CNT_W'(tail);
        if (t >= h) begin
            ring_count = t - h;
        end else begin
            ring_count = t + ring - h;
        end
    endfunction

    assign c_accept = i_in_valid && o_in_ready;

    // Capacity is limited to the number of slots less one.
    always_comb begin
        if (int'(r_cap) > SLOTS - 1) begin
            c_cap_eff = CAP_W'(SLOTS - 1);
        end else begin
            c_cap_eff = r_cap;
        end
    end

    assign c_top       = PTR_W'(c_cap_eff);
    assign c_ring      = CNT_W'(c_cap_eff) + CNT_W'(1);
    assign c_enabled   = (c_cap_eff != '0);
    assign c_count_cur = ring_count(r_head, r_tail, c_ring);
    assign c_not_full  = (c_count_cur < CNT_W'(c_cap_eff));

    // Pointer steps with wrap at the top slot of the ring.
    assign c_head_inc = (r_head == c_top) ? '0 : r_head + PTR_W'(1);
    assign c_tail_inc = (r_tail == c_top) ? '0 : r_tail + PTR_W'(1);
    assign c_head_dec = (r_head == '0) ? c_top : r_head - PTR_W'(1);

    // Operation decode.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        c_ok    = 1'b0;
        c_we    = 1'b0;
        c_waddr = r_tail;
        unique case (t_cmd'(i_command))
            CMD_APPEND: begin
                if (c_enabled && c_not_full) begin
                    c_ok   = 1'b1;
                    c_we   = c_accept;
                    n_tail = c_tail_inc;
                end
            end
            CMD_POP: begin
                if (c_count_cur != '0) begin
                    c_ok   = 1'b1;
                    n_head = c_head_inc;
                end
            end
            CMD_PREPEND: begin
                if (c_enabled && c_not_full) begin
                    c_ok    = 1'b1;
                    c_we    = c_accept;
                    c_waddr = c_head_dec;
                    n_head  = c_head_dec;
                end
            end
            CMD_STATUS: begin
                c_ok = c_enabled;
            end
            default: begin
                c_ok = 1'b0;
            end
        endcase
    end

    assign c_count_new = ring_count(n_head, n_tail, c_ring);

    // Transaction sequencing.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: state, capacity and pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_head <= '0;
                r_tail <= '0;
            end else if (c_accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
        end
    end

    // Result registers: status at acceptance, popped item once the read returns.
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_ok         <= c_ok;
            r_pop_ok     <= c_ok && (t_cmd'(i_command) == CMD_POP);
            r_item_count <= CAP_W'(c_count_new);
            r_free_count <= c_cap_eff - CAP_W'(c_count_new);
            r_full       <= (c_count_new == CNT_W'(c_cap_eff));
            r_empty      <= (c_count_new == '0);
        end
        if (r_state == S_READ) begin
            r_popped <= r_pop_ok ? r_rd_data : '0;
        end
    end

    // Slot memory: one write port, one registered read at the head.
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_waddr] <= i_item_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_ok          = r_ok;
    assign o_popped_data = r_popped;
    assign o_item_count  = r_item_count;
    assign o_free_count  = r_free_count;
    assign o_is_full     = r_full;
    assign o_is_empty    = r_empty;

    // Checks.
    `CQP_ASSERT_SAME(a_one_in_flight, i_clk, i_rst_n, o_out_valid, !o_in_ready,
        "input accepted while a result is pending")
    `CQP_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        c_count_cur <= CNT_W'(c_cap_eff), "queue holds more items than its capacity")
    `CQP_ASSERT_SAME(a_fail_no_data, i_clk, i_rst_n, o_out_valid && !o_ok,
        o_popped_data == '0, "failed operation returned nonzero popped data")
    `CQP_ASSERT_SAME(a_empty_mark, i_clk, i_rst_n, o_out_valid,
        o_is_empty == (o_item_count == '0), "empty mark disagrees with item count")

endmodule

// ===== dv/tb_circular_queue_with_prepend_core.sv =====
`timescale 1ns / 100ps

module tb_circular_queue_with_prepend_core;
    import cqp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 11;
    localparam int DRAIN_CYCLES = 8;

    // One queue operation as it goes into the block.
    typedef struct {
        t_cmd                 cmd;
        logic [ITEM_BITS-1:0] data;
    } t_queue_op;

    // One status reply as it comes out of the block.
    typedef struct {
        logic                 ok;
        logic [ITEM_BITS-1:0] popped;
        logic [CAP_W-1:0]     count;
        logic [CAP_W-1:0]     free;
        logic                 full;
        logic                 empty;
    } t_queue_reply;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_command   = CMD_STATUS;
    logic [ITEM_BITS-1:0] i_item_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_ok;
    logic [ITEM_BITS-1:0] o_popped_data;
    logic [CAP_W-1:0]     o_item_count;
    logic [CAP_W-1:0]     o_free_count;
    logic                 o_is_full;
    logic                 o_is_empty;

    // Shadow copy of the ring: slots, pointers and the capacity register.
    logic [ITEM_BITS-1:0] ring_slots [SLOTS];
    logic [PTR_W-1:0]     ring_head = '0;
    logic [PTR_W-1:0]     ring_tail = '0;
    logic [CAP_W-1:0]     ring_cap  = CAP_RESET;

    t_queue_op    op_backlog [$];
    t_queue_reply replies_due [$];
    t_queue_op    next_op;
    t_queue_reply want_reply;
    bit           steady      = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;

    circular_queue_with_prepend_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_item_data   (i_item_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_popped_data (o_popped_data),
        .o_item_count  (o_item_count),
        .o_free_count  (o_free_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow ring and returns the reply it should produce.
    function automatic t_queue_reply predict_reply(t_cmd cmd, logic [ITEM_BITS-1:0] data);
        t_queue_reply r;
        int ring;
        int used;
        r = '{ok: 1'b0, popped: '0, count: '0, free: '0, full: 1'b1, empty: 1'b1};
        if (ring_cap == 0) begin
            return r;
        end
        ring = int'(ring_cap) + 1;
        used = (int'(ring_tail) + ring - int'(ring_head)) % ring;
        case (cmd)
            CMD_APPEND: begin
                if (used < int'(ring_cap)) begin
                    ring_slots[ring_tail] = data;
                    ring_tail = (int'(ring_tail) + 1 == ring) ? '0 : ring_tail + 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (used != 0) begin
                    r.popped = ring_slots[ring_head];
                    ring_head = (int'(ring_head) + 1 == ring) ? '0 : ring_head + 1'b1;
                    r.ok = 1'b1;
                end
            end
            CMD_PREPEND: begin
                // The new head sits one slot before the old one, wrapping to the top slot.
                if (used < int'(ring_cap)) begin
                    ring_head = (ring_head == 0) ? PTR_W'(ring_cap) : ring_head - 1'b1;
                    ring_slots[ring_head] = data;
                    r.ok = 1'b1;
                end
            end
            default: begin
                r.ok = 1'b1;
            end
        endcase
        used    = (int'(ring_tail) + ring - int'(ring_head)) % ring;
        r.count = CAP_W'(used);
        r.free  = CAP_W'(int'(ring_cap) - used);
        r.full  = (used == int'(ring_cap));
        r.empty = (used == 0);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [ITEM_BITS-1:0] got,
                                 logic [ITEM_BITS-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Input driver: presents the next pending operation, with random idle cycles except in steady phases.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (op_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_op = op_backlog.pop_front();
                i_in_valid  <= 1'b1;
                i_command   <= next_op.cmd;
                i_item_data <= next_op.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                replies_due.push_back(predict_reply(t_cmd'(i_command), i_item_data));
            end
            if (o_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("output transaction with no operation outstanding");
                end else begin
                    want_reply = replies_due.pop_front();
                    compare_field("ok", ITEM_BITS'(o_ok), ITEM_BITS'(want_reply.ok));
                    compare_field("popped_data", o_popped_data, want_reply.popped);
                    compare_field("item_count", ITEM_BITS'(o_item_count),
                                  ITEM_BITS'(want_reply.count));
                    compare_field("free_count", ITEM_BITS'(o_free_count),
                                  ITEM_BITS'(want_reply.free));
                    compare_field("is_full", ITEM_BITS'(o_is_full),
                                  ITEM_BITS'(want_reply.full));
                    compare_field("is_empty", ITEM_BITS'(o_is_empty),
                                  ITEM_BITS'(want_reply.empty));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_circular_queue_with_prepend_core: done, errors");
            $finish;
        end
    end

    task automatic add_op(t_cmd cmd, logic [ITEM_BITS-1:0] data);
        op_backlog.push_back('{cmd: cmd, data: data});
    endtask

    // Waits until every operation has been sent and answered, then lets the pipe settle.
    task automatic wait_until_drained();
        while (op_backlog.size() != 0 || i_in_valid || replies_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writing the capacity also empties the ring.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_until_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        ring_cap  = cap;
        ring_head = '0;
        ring_tail = '0;
        @(negedge i_clk);
    endtask

    // Random traffic in alternating fill and drain runs so the ring swings
    // between empty and full.
    task automatic queue_random_ops(int n_ops);
        bit   filling;
        int   run_left;
        int   roll;
        t_cmd cmd;
        filling  = 1'b0;
        run_left = 0;
        for (int k = 0; k < n_ops; k++) begin
            if (run_left == 0) begin
                filling  = ~filling;
                run_left = $urandom_range(2 * int'(ring_cap) + 4, 2);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 8) begin
                cmd = CMD_STATUS;
            end else if ((roll < 80) == filling) begin
                cmd = $urandom_range(1) ? CMD_APPEND : CMD_PREPEND;
            end else begin
                cmd = CMD_POP;
            end
            add_op(cmd, $urandom);
        end
    endtask

    task automatic run_random_phase(logic [CAP_W-1:0] cap, int n_ops, bit no_idle);
        write_capacity(cap);
        steady = no_idle;
        queue_random_ops(n_ops);
        wait_until_drained();
        steady = 1'b0;
    endtask

    // Main sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: empty pop, both ends, extreme data, then drain past empty.
        add_op(CMD_STATUS, 32'h0000_0000);
        add_op(CMD_POP, 32'hFFFF_FFFF);
        add_op(CMD_APPEND, 32'h0000_0000);
        add_op(CMD_PREPEND, 32'hFFFF_FFFF);
        add_op(CMD_APPEND, 32'hA5A5_5A5A);
        add_op(CMD_STATUS, 32'h5A5A_A5A5);
        repeat (4) add_op(CMD_POP, 32'h0000_0000);

        // Small ring: append and prepend both refused when full.
        write_capacity(4'd2);
        add_op(CMD_APPEND, 32'h0000_0001);
        add_op(CMD_PREPEND, 32'h8000_0002);
        add_op(CMD_APPEND, 32'h0000_0003);
        add_op(CMD_PREPEND, 32'h0000_0004);
        add_op(CMD_STATUS, 32'h0000_0000);
        repeat (3) add_op(CMD_POP, 32'h0000_0000);

        // Disabled queue: every command fails.
        write_capacity(4'd0);
        add_op(CMD_APPEND, 32'h1234_5678);
        add_op(CMD_POP, 32'h0000_0000);
        add_op(CMD_PREPEND, 32'h8765_4321);
        add_op(CMD_STATUS, 32'h0000_0000);

        // Random phases over several capacities, one of them without any idling.
        run_random_phase(4'd15, 120, 1'b1);
        run_random_phase(4'd1, 60, 1'b0);
        run_random_phase(4'd0, 20, 1'b0);
        run_random_phase(4'd15, 120, 1'b0);
        run_random_phase(4'd7, 60, 1'b0);
        run_random_phase(4'd3, 60, 1'b0);
        for (int p = 0; p < 4; p++) begin
            run_random_phase(CAP_W'($urandom_range(15)), 50, 1'b0);
        end

        wait_until_drained();
        if (error_count == 0 && replies_due.size() == 0) begin
            $display("tb_circular_queue_with_prepend_core: done, clean");
        end else begin
            $display("tb_circular_queue_with_prepend_core: done, errors");
        end
        $finish;
    end

endmodule
